// ===== src/button_actuator_bind_assert.svh =====
// Assertion macros shared by the button actuator binding modules.
`ifndef BUTTON_ACTUATOR_BIND_ASSERT_SVH
`define BUTTON_ACTUATOR_BIND_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bab assertion failed");

// Next-cycle implication, checked outside reset.
`define BAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bab assertion failed");

`endif

// ===== src/bab_pkg.sv =====
// Types, register codes and constants for the button actuator binding.
package bab_pkg;

    localparam int unsigned MAX_POSITIONS = 4;
    localparam int unsigned IDX_W         = 2;
    localparam int unsigned CNT_W         = 3;
    localparam int unsigned CFG_ADDR_W    = 3;
    localparam int unsigned CFG_DATA_W    = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_BIND_MODE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HAS_SECONDARY  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_POSITION_COUNT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_POSITION_0     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_POSITION_1     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_POSITION_2     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_POSITION_3     = 3'd6;

    localparam logic [1:0] MODE_TOGGLE = 2'd0;
    localparam logic [1:0] MODE_HOLD   = 2'd1;
    localparam logic [1:0] MODE_STEP   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic KIND_SPEED = 1'b0;
    localparam logic KIND_MOVE  = 1'b1;

    localparam logic signed [7:0] FULL_SPEED     = 8'sd127;
    localparam logic signed [7:0] FULL_SPEED_NEG = -8'sd127;
    localparam logic signed [7:0] ZERO_SPEED     = 8'sd0;

    typedef struct packed {
        logic primary_pressed;
        logic secondary_pressed;
    } t_in;

    typedef struct packed {
        logic                command_kind;
        logic signed [7:0]   speed_value;
        logic signed [15:0]  target_position;
    } t_out;

    typedef struct packed {
        logic [1:0]                             bind_mode;
        logic                                   has_secondary;
        logic [CNT_W-1:0]                       position_count;
        logic [MAX_POSITIONS-1:0][CFG_DATA_W-1:0] position;
    } t_cfg;

endpackage

// ===== src/button_actuator_bind.sv =====
// Button actuator binding: top level.
// Input channel: one beat per control tick carries the primary and secondary
// button levels (i_in_valid / o_in_stall / i_in_data). Output channel: a beat
// carries one actuator command (o_out_valid / i_out_stall / o_out_data); a
// tick yields zero or one command depending on the bind mode and button edges.
// Configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_addr
// (0 mode, 1 has_secondary, 2 position count, 3..6 position table); write
// only while the block is idle.
// Path: a tick accepted into the input register has its command pushed into the
// result queue when it fires (tick held, queue not full); o_out_valid comes
// from the queue count register, and the beat leaves when not stalled.
// Throughput: one tick per cycle while the result queue is not full.
// Stall: results wait in a two-entry queue; while the receiver stalls, ticks
// keep flowing until the queue and the input register are full, then
// o_in_stall rises. o_in_stall is registered-only, with no path from
// i_out_stall.
// Reset (synchronous, active low): index 0, both buttons counted as released,
// registers at defaults (toggle mode, no secondary, count 1, table zero),
// queue empty.
module button_actuator_bind (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bab_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bab_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bab_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bab_pkg::t_out                   o_out_data
);
    import bab_pkg::*;

    t_cfg cfg;
    logic q_full;
    logic res_valid;
    t_out res_data;

    bab_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bab_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_res_valid (res_valid),
        .o_res_data  (res_data)
    );

    bab_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_data (res_data),
        .o_full      (q_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/bab_cfg.sv =====
// Configuration register file of the button actuator binding.
module bab_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bab_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bab_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output bab_pkg::t_cfg                   o_cfg
);
    import bab_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bind_mode      <= MODE_TOGGLE;
            r_cfg.has_secondary  <= 1'b0;
            r_cfg.position_count <= CNT_W'(1);
            r_cfg.position       <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_BIND_MODE:      r_cfg.bind_mode      <= i_cfg_wdata[1:0];
                REG_HAS_SECONDARY:  r_cfg.has_secondary  <= i_cfg_wdata[0];
                REG_POSITION_COUNT: r_cfg.position_count <= i_cfg_wdata[CNT_W-1:0];
                REG_POSITION_0:     r_cfg.position[0]    <= i_cfg_wdata;
                REG_POSITION_1:     r_cfg.position[1]    <= i_cfg_wdata;
                REG_POSITION_2:     r_cfg.position[2]    <= i_cfg_wdata;
                REG_POSITION_3:     r_cfg.position[3]    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/bab_core.sv =====
// Input register, binding state and per-tick command logic.
module bab_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bab_pkg::t_cfg  i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bab_pkg::t_in   i_in_data,
    input  logic           i_q_full,
    output logic           o_res_valid,
    output bab_pkg::t_out  o_res_data
);
    import bab_pkg::*;

    logic             r_a_valid;
    t_in              r_a_data;
    logic [IDX_W-1:0] r_idx;
    logic             r_prim_rel;
    logic             r_sec_rel;

    logic             n_a_valid;
    logic [IDX_W-1:0] n_idx;
    logic             accept;
    logic             fire;
    logic             prim;
    logic             sec;
    logic             prim_edge;
    logic             sec_edge;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] idx_fwd;
    logic             res_valid;
    t_out             res;

    assign o_in_stall = r_a_valid & i_q_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign fire       = r_a_valid & ~i_q_full;

    always_comb begin
        n_a_valid = r_a_valid;
        if (accept) begin
            n_a_valid = 1'b1;
        end else if (fire) begin
            n_a_valid = 1'b0;
        end
    end

    assign prim      = r_a_data.primary_pressed;
    assign sec       = i_cfg.has_secondary & r_a_data.secondary_pressed;
    assign prim_edge = prim & r_prim_rel;
    assign sec_edge  = sec & r_sec_rel;

    // count of zero acts as one, above the table size it saturates
    always_comb begin
        cnt_eff = i_cfg.position_count;
        if (i_cfg.position_count == '0) begin
            cnt_eff = CNT_W'(1);
        end else if (i_cfg.position_count > CNT_W'(MAX_POSITIONS)) begin
            cnt_eff = CNT_W'(MAX_POSITIONS);
        end
    end

    assign idx_ext = CNT_W'(r_idx);
    assign idx_fwd = idx_ext + CNT_W'(1);

    always_comb begin
        n_idx     = r_idx;
        res_valid = 1'b0;
        res       = '{command_kind: KIND_SPEED, speed_value: ZERO_SPEED,
                      target_position: '0};
        unique case (i_cfg.bind_mode)
            MODE_TOGGLE: begin
                if (prim_edge) begin
                    res_valid = 1'b1;
                    // any nonzero index counts as on
                    if (r_idx == '0) begin
                        n_idx           = IDX_W'(1);
                        res.speed_value = FULL_SPEED;
                    end else begin
                        n_idx = '0;
                    end
                end
            end
            MODE_HOLD: begin
                res_valid = 1'b1;
                priority if (prim) begin
                    res.speed_value = FULL_SPEED;
                end else if (sec) begin
                    res.speed_value = FULL_SPEED_NEG;
                end else begin
                    res.speed_value = ZERO_SPEED;
                end
            end
            MODE_STEP: begin
                priority if (prim_edge) begin
                    res_valid = 1'b1;
                    n_idx = (idx_fwd >= cnt_eff) ? '0 : idx_fwd[IDX_W-1:0];
                end else if (sec_edge) begin
                    res_valid = 1'b1;
                    if (r_idx == '0 || idx_ext >= cnt_eff) begin
                        n_idx = IDX_W'(cnt_eff - CNT_W'(1));
                    end else begin
                        n_idx = r_idx - IDX_W'(1);
                    end
                end else begin
                    n_idx = r_idx;
                end
                res.command_kind    = KIND_MOVE;
                res.speed_value     = FULL_SPEED;
                res.target_position = i_cfg.position[n_idx];
            end
            MODE_UNUSED: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_idx      <= '0;
            r_prim_rel <= 1'b1;
            r_sec_rel  <= 1'b1;
        end else begin
            r_a_valid <= n_a_valid;
            if (fire) begin
                r_idx      <= n_idx;
                r_prim_rel <= ~prim;
                r_sec_rel  <= ~sec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_data <= i_in_data;
        end
    end

    assign o_res_valid = fire & res_valid;
    assign o_res_data  = res;

`include "button_actuator_bind_assert.svh"

    `BAB_ASSERT_NOW(a_no_push_when_full, i_clk, i_rst_n, i_q_full, !o_res_valid)
    `BAB_ASSERT_NOW(a_step_is_move, i_clk, i_rst_n, o_res_valid && i_cfg.bind_mode == MODE_STEP, o_res_data.command_kind == KIND_MOVE && o_res_data.speed_value == FULL_SPEED)
    `BAB_ASSERT_NEXT(a_toggle_speed, i_clk, i_rst_n, o_res_valid && i_cfg.bind_mode == MODE_TOGGLE, (r_idx == '0) == ($past(o_res_data.speed_value) == ZERO_SPEED))

endmodule

// ===== src/bab_outq.sv =====
// Two-entry result queue that decouples the receiver's stall from the input side.
module bab_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bab_pkg::t_out  i_push_data,
    output logic           o_full,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bab_pkg::t_out  o_out_data
);
    import bab_pkg::*;

    t_out        r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        pop;

    assign o_full      = (r_count == 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign pop         = o_out_valid & ~i_out_stall;
    assign o_out_data  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        unique case ({i_push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            2'b00,
            2'b11:   n_count = r_count;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

`include "button_actuator_bind_assert.svh"

    `BAB_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count != 2'd3)
    `BAB_ASSERT_NOW(a_ptrs_track, i_clk, i_rst_n, r_count == 2'd0 || r_count == 2'd2, r_wptr == r_rptr)
    `BAB_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule
